FILE: hw/rtl/assert_macros.svh
// Assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on every rising clock edge, outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert an implication whose consequence must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pce_pkg.sv
`default_nettype none
package pce_pkg;
	localparam int unsigned MAX_POINTS_DEF = 6;
	localparam int unsigned NUM_EDGES = 12;
	localparam int unsigned EDGE_W = 4;
	localparam int unsigned COORD_W = 24;
	localparam int unsigned LIM_W = 15;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd1280;
	// Dividend is at most 2^41 in magnitude, quotient kept to 42 bits
	localparam int unsigned DIVD_W = 42;
	localparam int unsigned DIVS_W = 16;
	localparam int unsigned QBITS_PER_CYC = 3;
	localparam int unsigned DIV_STEPS = DIVD_W / QBITS_PER_CYC;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	// Per edge: sign on x, y, z as two bits each (01 plus, 11 minus, 00 free)
	typedef struct packed {
		logic [1:0] sx;
		logic [1:0] sy;
		logic [1:0] sz;
		axis_t      axis;
	} edge_t;

	function automatic edge_t edge_info(input logic [EDGE_W-1:0] e);
		edge_t r;
		r = '0;
		case (e)
			4'd0: r = '{2'b01, 2'b00, 2'b01, AX_Y};
			4'd1: r = '{2'b01, 2'b00, 2'b11, AX_Y};
			4'd2: r = '{2'b01, 2'b01, 2'b00, AX_Z};
			4'd3: r = '{2'b01, 2'b11, 2'b00, AX_Z};
			4'd4: r = '{2'b00, 2'b01, 2'b01, AX_X};
			4'd5: r = '{2'b00, 2'b01, 2'b11, AX_X};
			4'd6: r = '{2'b00, 2'b11, 2'b11, AX_X};
			4'd7: r = '{2'b00, 2'b11, 2'b01, AX_X};
			4'd8: r = '{2'b11, 2'b00, 2'b01, AX_Y};
			4'd9: r = '{2'b11, 2'b00, 2'b11, AX_Y};
			4'd10: r = '{2'b11, 2'b01, 2'b00, AX_Z};
			4'd11: r = '{2'b11, 2'b11, 2'b00, AX_Z};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Commands from controller to datapath
	typedef struct packed {
		logic                 load;      // capture plane, clear point count
		logic                 edge_prep; // compute numerator for edge
		logic [EDGE_W-1:0]    edge_idx;
		logic                 div_start;
		logic                 keep;      // test range and duplicates, store
	} pce_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic zero_div;
	} pce_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/plane_cube_edge_intersect_unit.sv
// Per plane: accept; for each edge prepare, start the divider, wait for done and keep (a
// zero divisor skips the division); then one result per cycle into the output register,
// unless out stalls. One plane at a time; the next is taken once the last result
// is loaded. The shared radix-8 divider (14 steps, then a done pulse) sets the edge time.
// Reset (arst_n low, asynchronous): edge_limit returns to 5.0, sequencer to idle,
// the point count to zero; the point store itself is not cleared.
`default_nettype none
module plane_cube_edge_intersect_unit #(
	parameter int unsigned MAX_POINTS = pce_pkg::MAX_POINTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pce_pkg::LIM_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [15:0]            coef_x,
	input  wire logic signed [15:0]            coef_y,
	input  wire logic signed [15:0]            coef_z,
	input  wire logic signed [15:0]            rhs_term,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [pce_pkg::COORD_W-1:0] point_x,
	output logic signed [pce_pkg::COORD_W-1:0] point_y,
	output logic signed [pce_pkg::COORD_W-1:0] point_z,
	output logic                               valid_res,
	output logic                               is_last
);
	localparam int unsigned NW = $clog2(MAX_POINTS + 1);
	localparam int unsigned IW = $clog2(MAX_POINTS);

	logic [pce_pkg::LIM_W-1:0] limit_q;
	pce_pkg::pce_cmd_t cmd;
	pce_pkg::pce_sts_t sts;
	logic [NW-1:0] count;
	logic [IW-1:0] rd_idx;
	logic signed [pce_pkg::COORD_W-1:0] rd_x, rd_y, rd_z;
	logic emit_load, emit_empty, emit_last, out_free;

	// Hold the cube half-size
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pce_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	pce_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.sts       (sts),
		.count     (count),
		.rd_idx    (rd_idx),
		.emit_load (emit_load),
		.emit_empty(emit_empty),
		.emit_last (emit_last),
		.out_free  (out_free)
	);

	pce_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.coef_x    (coef_x),
		.coef_y    (coef_y),
		.coef_z    (coef_z),
		.rhs_term  (rhs_term),
		.edge_limit(limit_q),
		.rd_idx    (rd_idx),
		.count     (count),
		.rd_x      (rd_x),
		.rd_y      (rd_y),
		.rd_z      (rd_z)
	);

	// Output register: load when empty or being drained
	assign out_free = !out_valid || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			point_x   <= emit_empty ? '0 : rd_x;
			point_y   <= emit_empty ? '0 : rd_y;
			point_z   <= emit_empty ? '0 : rd_z;
			valid_res <= !emit_empty;
			is_last   <= emit_last;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/pce_divider.sv
`default_nettype none
// Signed truncating divider, radix 8 restoring, three quotient bits a cycle
module pce_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [pce_pkg::DIVD_W-1:0] dividend,
	input  wire logic signed [pce_pkg::DIVS_W-1:0] divisor,
	output logic                                   busy,
	output logic                                   done,
	output logic signed [pce_pkg::DIVD_W-1:0]      quotient
);
	localparam int unsigned DW = pce_pkg::DIVD_W;
	localparam int unsigned SW = pce_pkg::DIVS_W;
	localparam int unsigned CW = $clog2(pce_pkg::DIV_STEPS + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [SW:0]   part_q;
	logic [SW-1:0] dvs_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;

	logic [DW-1:0] dvd_mag;
	logic [SW-1:0] dvs_mag;
	logic [SW:0]   p0, p1, p2, p3;
	logic [SW:0]   d1, d2, d3;
	logic          b1, b2, b3;

	assign dvd_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	assign dvs_mag = divisor[SW-1] ? SW'(-divisor) : SW'(divisor);

	// Three restoring steps per cycle
	always_comb begin
		p0 = part_q;
		p1 = {p0[SW-1:0], rem_q[DW-1]};
		d1 = p1 - {1'b0, dvs_q};
		b1 = (p1 >= {1'b0, dvs_q});
		p1 = b1 ? d1 : p1;
		p2 = {p1[SW-1:0], rem_q[DW-2]};
		d2 = p2 - {1'b0, dvs_q};
		b2 = (p2 >= {1'b0, dvs_q});
		p2 = b2 ? d2 : p2;
		p3 = {p2[SW-1:0], rem_q[DW-3]};
		d3 = p3 - {1'b0, dvs_q};
		b3 = (p3 >= {1'b0, dvs_q});
		p3 = b3 ? d3 : p3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= CW'(pce_pkg::DIV_STEPS);
			end else if (busy) begin
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dvd_mag;
			quo_q  <= '0;
			part_q <= '0;
			dvs_q  <= dvs_mag;
			neg_q  <= dividend[DW-1] ^ divisor[SW-1];
		end else if (busy) begin
			rem_q  <= {rem_q[DW-4:0], 3'b000};
			quo_q  <= {quo_q[DW-4:0], b1, b2, b3};
			part_q <= p3;
		end
	end

	assign quotient = neg_q ? DW'(-quo_q) : DW'(quo_q);
endmodule
`default_nettype wire

FILE: hw/rtl/pce_datapath.sv
`default_nettype none
// Plane registers, numerator, divider, range check and point store
module pce_datapath #(
	parameter int unsigned MAX_POINTS = pce_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire pce_pkg::pce_cmd_t                     cmd,
	output pce_pkg::pce_sts_t                          sts,
	input  wire logic signed [15:0]                    coef_x,
	input  wire logic signed [15:0]                    coef_y,
	input  wire logic signed [15:0]                    coef_z,
	input  wire logic signed [15:0]                    rhs_term,
	input  wire logic [pce_pkg::LIM_W-1:0]             edge_limit,
	input  wire logic [$clog2(MAX_POINTS)-1:0]         rd_idx,
	output logic [$clog2(MAX_POINTS+1)-1:0]            count,
	output logic signed [pce_pkg::COORD_W-1:0]         rd_x,
	output logic signed [pce_pkg::COORD_W-1:0]         rd_y,
	output logic signed [pce_pkg::COORD_W-1:0]         rd_z
);
	localparam int unsigned CW = pce_pkg::COORD_W;
	localparam int unsigned DW = pce_pkg::DIVD_W;
	localparam int unsigned NW = $clog2(MAX_POINTS + 1);
	localparam int unsigned IW = $clog2(MAX_POINTS);

	logic signed [15:0] cx_q, cy_q, cz_q, d_q;
	logic [pce_pkg::LIM_W-1:0] lim_q;
	logic signed [CW-1:0] fx_q, fy_q, fz_q;
	pce_pkg::axis_t ax_q;
	logic signed [DW-1:0] num_q;
	logic signed [15:0] dvs_q;
	logic zero_q;

	logic signed [CW-1:0] st_x [MAX_POINTS];
	logic signed [CW-1:0] st_y [MAX_POINTS];
	logic signed [CW-1:0] st_z [MAX_POINTS];
	logic [NW-1:0] cnt_q;

	pce_pkg::edge_t ed;
	logic signed [16:0] lim_s;
	logic signed [16:0] ux, uy, uz;
	logic signed [33:0] prod_p, prod_q;
	logic signed [15:0] cax;
	logic signed [DW-1:0] num_c;

	logic div_busy, div_done;
	logic signed [DW-1:0] quo;
	logic signed [DW-1:0] lim16;
	logic in_range, dup;
	logic signed [CW-1:0] px, py, pz;

	function automatic logic signed [16:0] sgn_lim(input logic [1:0] s,
			input logic signed [16:0] l);
		logic signed [16:0] r;
		r = '0;
		case (s)
			2'b01: r = l;
			2'b11: r = -l;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Fixed coordinates and the numerator for the current edge
	always_comb begin
		ed    = pce_pkg::edge_info(cmd.edge_idx);
		lim_s = {2'b00, lim_q};
		ux    = sgn_lim(ed.sx, lim_s);
		uy    = sgn_lim(ed.sy, lim_s);
		uz    = sgn_lim(ed.sz, lim_s);
		cax = '0;
		prod_p = '0; prod_q = '0;
		unique case (ed.axis)
			pce_pkg::AX_X: begin
				cax = cx_q; prod_p = cy_q * uy; prod_q = cz_q * uz;
			end
			pce_pkg::AX_Y: begin
				cax = cy_q; prod_p = cx_q * ux; prod_q = cz_q * uz;
			end
			default: begin
				cax = cz_q; prod_p = cx_q * ux; prod_q = cy_q * uy;
			end
		endcase
		num_c = (DW'(d_q) <<< 16) - (DW'(prod_p) <<< 8) - (DW'(prod_q) <<< 8);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q  <= coef_x;
			cy_q  <= coef_y;
			cz_q  <= coef_z;
			d_q   <= rhs_term;
			lim_q <= edge_limit;
		end
		if (cmd.edge_prep) begin
			num_q  <= num_c;
			dvs_q  <= cax;
			zero_q <= (cax == 16'sd0);
			ax_q   <= ed.axis;
			fx_q   <= CW'(ux) <<< 8;
			fy_q   <= CW'(uy) <<< 8;
			fz_q   <= CW'(uz) <<< 8;
		end
	end

	pce_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(num_q),
		.divisor (dvs_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quo)
	);

	// Range test, candidate point and duplicate search
	always_comb begin
		lim16    = DW'({1'b0, lim_q}) <<< 8;
		in_range = (quo <= lim16) && (quo >= -lim16);
		px = fx_q; py = fy_q; pz = fz_q;
		unique case (ax_q)
			pce_pkg::AX_X: px = quo[CW-1:0];
			pce_pkg::AX_Y: py = quo[CW-1:0];
			default:       pz = quo[CW-1:0];
		endcase
		dup = 1'b0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (NW'(i) < cnt_q && st_x[i] == px && st_y[i] == py && st_z[i] == pz)
				dup = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.keep && in_range && !dup && cnt_q < NW'(MAX_POINTS)) begin
			cnt_q <= cnt_q + NW'(1);
		end
	end

	// Store the kept point
	always_ff @(posedge clk) begin
		if (cmd.keep && in_range && !dup && cnt_q < NW'(MAX_POINTS)) begin
			st_x[cnt_q[IW-1:0]] <= px;
			st_y[cnt_q[IW-1:0]] <= py;
			st_z[cnt_q[IW-1:0]] <= pz;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.zero_div = zero_q;
	assign count = cnt_q;
	assign rd_x  = st_x[rd_idx];
	assign rd_y  = st_y[rd_idx];
	assign rd_z  = st_z[rd_idx];
endmodule
`default_nettype wire

FILE: hw/rtl/pce_ctrl.sv
`default_nettype none
// Sequencer over the cube edges and the emit phase
module pce_ctrl #(
	parameter int unsigned MAX_POINTS = pce_pkg::MAX_POINTS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	output pce_pkg::pce_cmd_t                       cmd,
	input  wire pce_pkg::pce_sts_t                  sts,
	input  wire logic [$clog2(MAX_POINTS+1)-1:0]    count,
	output logic [$clog2(MAX_POINTS)-1:0]           rd_idx,
	output logic                                    emit_load,
	output logic                                    emit_empty,
	output logic                                    emit_last,
	input  wire logic                               out_free
);
	localparam int unsigned NW = $clog2(MAX_POINTS + 1);
	localparam int unsigned IW = $clog2(MAX_POINTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_WAIT,
		ST_KEEP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [pce_pkg::EDGE_W-1:0] edge_q;
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
						edge_q  <= '0;
					end
				end
				ST_PREP: state_q <= ST_START;
				ST_START: begin
					state_q <= sts.zero_div ? ST_KEEP : ST_WAIT;
				end
				ST_WAIT: if (sts.div_done) state_q <= ST_KEEP;
				ST_KEEP: begin
					if (edge_q == pce_pkg::EDGE_W'(pce_pkg::NUM_EDGES - 1)) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end else begin
						edge_q  <= edge_q + pce_pkg::EDGE_W'(1);
						state_q <= ST_PREP;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (count == '0 || NW'(idx_q) + NW'(1) >= count) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Keep only when the division ran on a nonzero divisor
	logic zero_seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_seen_q <= 1'b0;
		end else if (state_q == ST_START) begin
			zero_seen_q <= sts.zero_div;
		end
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.edge_prep = (state_q == ST_PREP);
		cmd.edge_idx  = edge_q;
		cmd.div_start = (state_q == ST_START) && !sts.zero_div;
		cmd.keep      = (state_q == ST_KEEP) && !zero_seen_q;
		rd_idx        = idx_q;
		emit_load     = (state_q == ST_EMIT) && out_free;
		emit_empty    = (count == '0);
		emit_last     = (count == '0) || (NW'(idx_q) + NW'(1) >= count);
	end
endmodule
`default_nettype wire

FILE: hw/rtl/pce_checker.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the top level
module pce_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic valid_res,
	input wire logic is_last
);
	logic [1:0] inflight_q;
	logic       acc, fin;

	assign acc = in_valid && in_ready;
	assign fin = out_valid && out_ready && is_last;

	// Count planes taken whose last result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else if (acc && !fin) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (fin && !acc) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, inflight_q == 2'd2, !in_ready, "item accepted while busy")
	`ASSERT_IMPL(a_out_only_busy, clk, arst_n, out_valid, inflight_q != 2'd0, "result without item")
	`ASSERT_IMPL(a_empty_is_last, clk, arst_n, out_valid && !valid_res, is_last,
		"empty result not last")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind plane_cube_edge_intersect_unit pce_checker u_pce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.valid_res(valid_res),
	.is_last  (is_last)
);
`default_nettype wire

FILE: test/plane_checker.sv
`timescale 1ns / 1ps
module plane_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] coef_x,
	input  logic signed [15:0] coef_y,
	input  logic signed [15:0] coef_z,
	input  logic signed [15:0] rhs_term,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	input  logic               valid_res,
	input  logic               is_last,
	output int                 errors,
	output int                 pending,
	output int                 points_seen,
	output int                 empty_seen
);
	localparam int NPTS = 6;

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic               hit;
		logic               last;
	} cube_point_t;

	// signs of L on x, y, z per edge; solved axis has 0
	localparam int EDGE_SX[12] = '{1, 1, 1, 1, 0, 0, 0, 0, -1, -1, -1, -1};
	localparam int EDGE_SY[12] = '{0, 0, 1, -1, 1, 1, -1, -1, 0, 0, 1, -1};
	localparam int EDGE_SZ[12] = '{1, -1, 0, 0, 1, -1, -1, 1, 1, -1, 0, 0};

	logic [14:0] half_size;
	cube_point_t expected_points[$];

	assign pending = expected_points.size();

	task automatic report(input string what, input longint got, input longint want);
		$display("[%0t] %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// intersect one plane with the cube edges and queue the kept points, or one empty result if none
	task automatic intersect_plane(input longint a, input longint b, input longint c,
			input longint d);
		longint coef[3];
		longint lim;
		longint fix[3];
		longint pt[3];
		longint num;
		longint q;
		longint kx[NPTS], ky[NPTS], kz[NPTS];
		int count;
		int ax;
		bit dup;
		cube_point_t r;
		coef[0] = a; coef[1] = b; coef[2] = c;
		lim = half_size;
		count = 0;
		for (int e = 0; e < 12; e++) begin
			fix[0] = EDGE_SX[e] * lim;
			fix[1] = EDGE_SY[e] * lim;
			fix[2] = EDGE_SZ[e] * lim;
			ax = (EDGE_SX[e] == 0) ? 0 : (EDGE_SY[e] == 0) ? 1 : 2;
			if (coef[ax] == 0) continue;
			num = d * 256;
			for (int k = 0; k < 3; k++) begin
				if (k != ax) num -= coef[k] * fix[k];
				pt[k] = fix[k] * 256;
			end
			q = (num * 256) / coef[ax];
			if (q > lim * 256 || q < -lim * 256) continue;
			pt[ax] = q;
			dup = 0;
			for (int i = 0; i < count; i++)
				if (kx[i] == pt[0] && ky[i] == pt[1] && kz[i] == pt[2]) dup = 1;
			if (dup || count >= NPTS) continue;
			kx[count] = pt[0]; ky[count] = pt[1]; kz[count] = pt[2];
			count++;
		end
		if (count == 0) begin
			r = '{24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1};
			expected_points.push_back(r);
		end
		for (int i = 0; i < count; i++) begin
			r.px = kx[i][23:0];
			r.py = ky[i][23:0];
			r.pz = kz[i][23:0];
			r.hit = 1'b1;
			r.last = (i == count - 1);
			expected_points.push_back(r);
		end
	endtask

	// track config, predict on accepted planes, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		cube_point_t w;
		if (!arst_n) begin
			half_size <= 15'd1280;
			errors = 0;
			points_seen = 0;
			empty_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) half_size <= cfg_data;
			if (in_valid && in_ready) intersect_plane(coef_x, coef_y, coef_z, rhs_term);
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report("unexpected result", point_x, 0);
				end else begin
					w = expected_points.pop_front();
					if (valid_res) points_seen++; else empty_seen++;
					if (point_x !== w.px) report("point_x", point_x, w.px);
					if (point_y !== w.py) report("point_y", point_y, w.py);
					if (point_z !== w.pz) report("point_z", point_z, w.pz);
					if (valid_res !== w.hit) report("valid_res", valid_res, w.hit);
					if (is_last !== w.last) report("is_last", is_last, w.last);
				end
			end
		end
	end
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [14:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] coef_x, coef_y, coef_z, rhs_term;
	logic               out_valid;
	logic               out_ready;
	logic signed [23:0] point_x, point_y, point_z;
	logic               valid_res, is_last;
	int                 errors, pending, points_seen, empty_seen;
	int                 stall_hold;
	int                 planes_sent;
	bit                 gen_done;

	plane_cube_edge_intersect_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.coef_x(coef_x), .coef_y(coef_y), .coef_z(coef_z), .rhs_term(rhs_term),
		.out_valid(out_valid), .out_ready(out_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.valid_res(valid_res), .is_last(is_last)
	);

	plane_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		out_ready <= 0;
		@(posedge clk iff arst_n);
		forever begin
			if (stall_hold > 0) begin
				out_ready <= 0;
				repeat (stall_hold) @(posedge clk);
				stall_hold = 0;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				if (gap > 0) begin
					out_ready <= 0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_plane(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		coef_x <= a; coef_y <= b; coef_z <= c; rhs_term <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		planes_sent++;
	endtask

	task automatic write_half_size(input logic [14:0] v);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	// random coefficient: zero, 16'h7FFF, 16'h8000, plus or minus 16'h0100, or any value
	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [14:0] limits[5];
		arst_n = 0;
		cfg_valid = 0; cfg_data = 0;
		in_valid = 0; coef_x = 0; coef_y = 0; coef_z = 0; rhs_term = 0;
		stall_hold = 0; planes_sent = 0; gen_done = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset size, axis planes, all-zero, extremes, diagonal
		send_plane(16'h0100, 0, 0, 0, 0);
		send_plane(0, 16'h0100, 0, 16'h0200, 0);
		send_plane(0, 0, 16'h0100, 16'hFB00, 0);
		send_plane(0, 0, 0, 0, 0);
		send_plane(0, 0, 0, 16'h7FFF, 0);
		send_plane(16'h0100, 16'h0100, 16'h0100, 0, 0);
		send_plane(16'h0100, 16'h0100, 16'h0100, 16'h0F00, 0);
		send_plane(16'h0100, 16'h0100, 0, 0, 0);
		send_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
		send_plane(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0);
		send_plane(16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 0);
		send_plane(16'h0100, 16'h0100, 16'h0100, 16'h0500, 0);

		// full back pressure while planes keep coming
		stall_hold = 400;
		repeat (6) send_plane(16'h0100, 16'h0200, 16'hFF00, 16'($urandom), 1);

		limits = '{15'd0, 15'd32767, 15'd1, 15'd256, 15'd1280};
		foreach (limits[i]) begin
			write_half_size(limits[i]);
			send_plane(16'h0100, 16'h0100, 16'h0100, 0, 0);
			send_plane(16'h0100, 0, 0, 16'h0000, 0);
			send_plane(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 0);
			for (int n = 0; n < 30; n++) begin
				if ($urandom_range(0, 3) == 0)
					send_plane(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), n % 5 == 0);
				else
					send_plane(rand_coef(), rand_coef(), rand_coef(),
						$urandom_range(0, 1) ? 16'($urandom_range(0, 2047) - 1024)
							: 16'($urandom), n % 5 == 0);
			end
		end
		write_half_size(15'($urandom));
		repeat (10) send_plane(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 0);
		in_valid <= 0;

		gen_done = 1;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d planes over several cube sizes; checked %0d points, %0d empty.",
			planes_sent, points_seen, empty_seen);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
